/* design/three_key_debouncer_defines.svh */
// assertion macros for the three-key debouncer
// no dependencies; included by the top level only
`ifndef THREE_KEY_DEBOUNCER_DEFINES_SVH
`define THREE_KEY_DEBOUNCER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define TKD_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define TKD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tkd_pkg.sv */
// shared types and constants of the three-key debouncer
// no dependencies; imported by every module of the block
package tkd_pkg;

    localparam int NUM_KEYS = 3;
    localparam int KEY_DEC  = 0;
    localparam int KEY_INC  = 1;
    localparam int KEY_SET  = 2;

    // joystick windows, 10-bit axis
    localparam logic [9:0] JOY_DEC_PRESS_MAX = 10'd60;
    localparam logic [9:0] JOY_INC_PRESS_MIN = 10'd800;
    localparam logic [9:0] JOY_DEC_REL_LOW   = 10'd400;
    localparam logic [9:0] JOY_DEC_REL_HIGH  = 10'd600;
    localparam logic [9:0] JOY_INC_REL_HIGH  = 10'd700;
    localparam logic [9:0] JOY_INC_REL_LOW   = 10'd300;

    // configuration register indexes
    localparam logic [1:0] CFG_INPUT_MODE     = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE_COUNT = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_PERIOD  = 2'd2;

    localparam logic       MODE_BUTTON   = 1'b0;
    localparam logic       MODE_JOYSTICK = 1'b1;

    localparam logic [3:0]  DEBOUNCE_COUNT_RST = 4'd4;
    localparam logic [15:0] SAMPLE_PERIOD_RST  = 16'd10;

    // what one sample says about one key
    typedef struct packed {
        logic pressed;
        logic released;
    } key_reading_t;

    // outcome of one tick for one key
    typedef struct packed {
        logic press_evt;
        logic release_evt;
        logic held;
    } key_result_t;

endpackage

/* design/tkd_key_sense.sv */
// turns raw pin and joystick levels into pressed / released readings per key
// depends on tkd_pkg
module tkd_key_sense
    import tkd_pkg::*;
(
    input  logic                               input_mode,
    input  logic [9:0]                         joystick_level,
    input  logic [NUM_KEYS-1:0]                pin_levels,
    output key_reading_t [NUM_KEYS-1:0]        readings
);

    logic joy_mode;

    assign joy_mode = (input_mode == MODE_JOYSTICK);

    always_comb
    begin
        // set key is always an active-low pin
        readings[KEY_SET].pressed  = ~pin_levels[KEY_SET];
        readings[KEY_SET].released = pin_levels[KEY_SET];

        if (joy_mode)
        begin
            readings[KEY_DEC].pressed  = (joystick_level <= JOY_DEC_PRESS_MAX);
            readings[KEY_DEC].released = (joystick_level >= JOY_DEC_REL_LOW) &&
                                         (joystick_level <  JOY_DEC_REL_HIGH);
            readings[KEY_INC].pressed  = (joystick_level >= JOY_INC_PRESS_MIN);
            readings[KEY_INC].released = (joystick_level >  JOY_INC_REL_LOW) &&
                                         (joystick_level <= JOY_INC_REL_HIGH);
        end
        else
        begin
            readings[KEY_DEC].pressed  = ~pin_levels[KEY_DEC];
            readings[KEY_DEC].released = pin_levels[KEY_DEC];
            readings[KEY_INC].pressed  = ~pin_levels[KEY_INC];
            readings[KEY_INC].released = pin_levels[KEY_INC];
        end
    end

endmodule

/* design/tkd_key_unit.sv */
// debounce state of one key: held flag and agreeing-sample counter
// depends on tkd_pkg
module tkd_key_unit
    import tkd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  key_reading_t reading,
    input  logic [3:0]   debounce_count,
    output key_result_t  result
);

    logic       held_reg;
    logic       held_next;
    logic [3:0] agree_count_reg;
    logic [3:0] agree_count_next;
    logic [3:0] count_inc;
    logic       agree;
    logic       flip;

    assign agree     = held_reg ? reading.released : reading.pressed;
    assign count_inc = agree_count_reg + 4'd1;
    // a count of zero acts like one: the first agreeing sample flips
    assign flip      = agree && (count_inc >= debounce_count);

    always_comb
    begin
        held_next        = held_reg;
        agree_count_next = agree_count_reg;
        if (step)
        begin
            if (!agree)
            begin
                agree_count_next = 4'd0;
            end
            else if (flip)
            begin
                agree_count_next = 4'd0;
                held_next        = ~held_reg;
            end
            else
            begin
                agree_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= 1'b0;
            agree_count_reg <= 4'd0;
        end
        else
        begin
            held_reg        <= held_next;
            agree_count_reg <= agree_count_next;
        end
    end

    assign result.press_evt   = step && flip && !held_reg;
    assign result.release_evt = step && flip && held_reg;
    assign result.held        = held_next;

endmodule

/* design/three_key_debouncer.sv */
// top level of the three-key debouncer: config registers, tick counter,
// input and result registers; depends on tkd_pkg, tkd_key_sense, tkd_key_unit
// and three_key_debouncer_defines.svh

// Three-key debouncer (decrement, increment, set). Each item is one
// millisecond tick with the raw key levels; each tick gives exactly one
// result item. A key sample is taken once the ticks since the last sample
// exceed sample_period; a key flips after debounce_count agreeing samples
// and reports a press or release event in that tick's result. In joystick
// mode decrement and increment come from the 10-bit axis with hysteresis
// windows, set stays an active-low pin.
// Throughput: one item per clock cycle unless out_ready stalls the result
// register. Items pass the input register, then the result register; the
// key state updates as an item moves from the input register to the result
// register. Configuration writes are always accepted (cfg_ready is tied
// high) and must only be issued while the block is idle.
`include "three_key_debouncer_defines.svh"

module three_key_debouncer
    import tkd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // tick item in
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [9:0]  joystick_level,
    input  logic        dec_pin_level,
    input  logic        inc_pin_level,
    input  logic        set_pin_level,

    // result item out
    output logic        out_valid,
    input  logic        out_ready,
    output logic        sampled,
    output logic [2:0]  press_events,
    output logic [2:0]  release_events,
    output logic [2:0]  held_keys
);

    // configuration registers
    logic        input_mode_reg;
    logic [3:0]  debounce_count_reg;
    logic [15:0] sample_period_reg;

    // input register
    logic                s1_valid_reg;
    logic [9:0]          s1_joy_reg;
    logic [NUM_KEYS-1:0] s1_pins_reg;

    // tick counter since the last sample
    logic [15:0] ticks_reg;
    logic [15:0] ticks_next;
    logic [16:0] elapsed;
    logic        take_sample;

    // result register
    logic                out_valid_reg;
    logic                sampled_reg;
    logic [NUM_KEYS-1:0] press_reg;
    logic [NUM_KEYS-1:0] release_reg;
    logic [NUM_KEYS-1:0] held_reg;

    logic         s1_fire;
    logic         key_step;
    key_reading_t [NUM_KEYS-1:0] readings;
    key_result_t  [NUM_KEYS-1:0] key_results;
    logic [NUM_KEYS-1:0] press_vec;
    logic [NUM_KEYS-1:0] release_vec;
    logic [NUM_KEYS-1:0] held_vec;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_mode_reg     <= MODE_BUTTON;
            debounce_count_reg <= DEBOUNCE_COUNT_RST;
            sample_period_reg  <= SAMPLE_PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INPUT_MODE:     input_mode_reg     <= cfg_data[0];
                CFG_DEBOUNCE_COUNT: debounce_count_reg <= cfg_data[3:0];
                CFG_SAMPLE_PERIOD:  sample_period_reg  <= cfg_data;
                default:            ; // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: the input register moves forward whenever the result
    // register is empty or being drained this cycle
    // ------------------------------------------------------------------
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_joy_reg  <= joystick_level;
            s1_pins_reg <= {set_pin_level, inc_pin_level, dec_pin_level};
        end
    end

    // ------------------------------------------------------------------
    // sample timing: elapsed is one bit wider so a period of 65535
    // still samples once every 65536 ticks and the counter never wraps
    // ------------------------------------------------------------------
    assign elapsed     = {1'b0, ticks_reg} + 17'd1;
    assign take_sample = (elapsed > {1'b0, sample_period_reg});
    assign ticks_next  = take_sample ? 16'd0 : elapsed[15:0];
    assign key_step    = s1_fire && take_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= 16'd0;
        end
        else if (s1_fire)
        begin
            ticks_reg <= ticks_next;
        end
    end

    // ------------------------------------------------------------------
    // per-key readings and debounce state
    // ------------------------------------------------------------------
    tkd_key_sense u_sense (
        .input_mode     (input_mode_reg),
        .joystick_level (s1_joy_reg),
        .pin_levels     (s1_pins_reg),
        .readings       (readings)
    );

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        tkd_key_unit u_key (
            .clk            (clk),
            .rst_n          (rst_n),
            .step           (key_step),
            .reading        (readings[k]),
            .debounce_count (debounce_count_reg),
            .result         (key_results[k])
        );

        assign press_vec[k]   = key_results[k].press_evt;
        assign release_vec[k] = key_results[k].release_evt;
        assign held_vec[k]    = key_results[k].held;
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            sampled_reg <= take_sample;
            press_reg   <= press_vec;
            release_reg <= release_vec;
            held_reg    <= held_vec;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sampled        = sampled_reg;
    assign press_events   = press_reg;
    assign release_events = release_reg;
    assign held_keys      = held_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // events only come with a sample
    `TKD_ASSERT_NOW(a_events_need_sample, clk, rst_n, out_valid && !sampled,
        (press_events == 3'd0) && (release_events == 3'd0),
        "event reported on a tick without a sample")

    // a press leaves the key held, a release leaves it released
    `TKD_ASSERT_NOW(a_event_matches_held, clk, rst_n, out_valid,
        ((press_events & ~held_keys) == 3'd0) && ((release_events & held_keys) == 3'd0),
        "event disagrees with debounced held state")

    // a tick without a sample advances the counter by one
    `TKD_ASSERT_NEXT(a_tick_count, clk, rst_n, s1_fire && !take_sample,
        ticks_reg == ($past(ticks_reg) + 16'd1),
        "tick counter did not advance")

    // a sampled tick restarts the counter
    `TKD_ASSERT_NEXT(a_tick_restart, clk, rst_n, key_step,
        (ticks_reg == 16'd0) && out_valid && sampled,
        "sample did not restart the tick counter")

endmodule

/* test/three_key_debouncer_checker.sv */
// result checker for the three-key debouncer: predicts one result item per tick
// depends on tkd_pkg; instantiated by three_key_debouncer_test
`timescale 1ns / 1ps

module three_key_debouncer_checker
    import tkd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [9:0]  joystick_level,
    input  logic        dec_pin_level,
    input  logic        inc_pin_level,
    input  logic        set_pin_level,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        sampled,
    input  logic [2:0]  press_events,
    input  logic [2:0]  release_events,
    input  logic [2:0]  held_keys,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic       sampled;
        logic [2:0] press;
        logic [2:0] release_mask;
        logic [2:0] held;
    } tick_result_t;

    // shadow configuration
    logic        mode_cfg;
    logic [3:0]  count_cfg;
    logic [15:0] period_cfg;

    // shadow key state
    logic [2:0]  key_held;
    logic [3:0]  agree_cnt [NUM_KEYS];
    logic [15:0] ticks_since;

    tick_result_t tick_results_q [$];
    tick_result_t want;

    function automatic key_reading_t read_key(input int k, input logic [9:0] joy,
                                              input logic pin);
        key_reading_t rd;
        if (mode_cfg == MODE_JOYSTICK && k == KEY_DEC) begin
            rd.pressed  = (joy <= JOY_DEC_PRESS_MAX);
            rd.released = (joy >= JOY_DEC_REL_LOW) && (joy < JOY_DEC_REL_HIGH);
        end else if (mode_cfg == MODE_JOYSTICK && k == KEY_INC) begin
            rd.pressed  = (joy >= JOY_INC_PRESS_MIN);
            rd.released = (joy > JOY_INC_REL_LOW) && (joy <= JOY_INC_REL_HIGH);
        end else begin
            rd.pressed  = (pin == 1'b0);
            rd.released = (pin != 1'b0);
        end
        return rd;
    endfunction

    // one tick through the debouncer, expected result queued
    task automatic debounce_tick(input logic [9:0] joy, input logic [2:0] pins);
        tick_result_t r;
        logic [16:0]  elapsed;
        key_reading_t rd;
        logic         agree;
        r = '0;
        elapsed = {1'b0, ticks_since} + 17'd1;
        if (elapsed > {1'b0, period_cfg}) begin
            r.sampled = 1'b1;
            ticks_since = '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                rd = read_key(k, joy, pins[k]);
                agree = key_held[k] ? rd.released : rd.pressed;
                if (!agree) begin
                    agree_cnt[k] = '0;
                end else begin
                    agree_cnt[k] = agree_cnt[k] + 4'd1;
                    // a zero count behaves like one here
                    if (agree_cnt[k] >= count_cfg) begin
                        agree_cnt[k] = '0;
                        if (key_held[k])
                            r.release_mask[k] = 1'b1;
                        else
                            r.press[k] = 1'b1;
                        key_held[k] = ~key_held[k];
                    end
                end
            end
        end else begin
            ticks_since = elapsed[15:0];
        end
        r.held = key_held;
        tick_results_q.push_back(r);
    endtask

    task automatic check_field(input string field, input logic [2:0] want_v,
                               input logic [2:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_cfg    = MODE_BUTTON;
            count_cfg   = DEBOUNCE_COUNT_RST;
            period_cfg  = SAMPLE_PERIOD_RST;
            key_held    = '0;
            ticks_since = '0;
            for (int k = 0; k < NUM_KEYS; k++)
                agree_cnt[k] = '0;
            tick_results_q.delete();
            fail_count    = 0;
            pending_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_INPUT_MODE:     mode_cfg   = cfg_data[0];
                    CFG_DEBOUNCE_COUNT: count_cfg  = cfg_data[3:0];
                    CFG_SAMPLE_PERIOD:  period_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (tick_results_q.size() == 0) begin
                    $error("result item with no tick waiting");
                    fail_count++;
                end else begin
                    want = tick_results_q.pop_front();
                    check_field("sampled", {2'b00, want.sampled}, {2'b00, sampled});
                    check_field("press_events", want.press, press_events);
                    check_field("release_events", want.release_mask, release_events);
                    check_field("held_keys", want.held, held_keys);
                end
            end
            if (in_valid && in_ready)
                debounce_tick(joystick_level, {set_pin_level, inc_pin_level, dec_pin_level});
            pending_count = tick_results_q.size();
        end
    end

endmodule

/* test/three_key_debouncer_test.sv */
// stimulus and verdict for the three-key debouncer
// depends on tkd_pkg, three_key_debouncer and three_key_debouncer_checker
`timescale 1ns / 1ps

module three_key_debouncer_test;
    import tkd_pkg::*;

    logic        clk;
    logic        rst_n;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    logic        in_valid;
    logic        in_ready;
    logic [9:0]  joystick_level;
    logic        dec_pin_level;
    logic        inc_pin_level;
    logic        set_pin_level;

    logic        out_valid;
    logic        out_ready;
    logic        sampled;
    logic [2:0]  press_events;
    logic [2:0]  release_events;
    logic [2:0]  held_keys;

    int          fail_count;
    int          pending_count;

    // sender burst bookkeeping; full_speed turns off all idling on both sides
    int          burst_left;
    logic        full_speed;

    // joystick zones used to build well-formed key sequences
    localparam int ZONE_DEC_PRESS = 0;
    localparam int ZONE_RELEASE   = 1;
    localparam int ZONE_INC_PRESS = 2;
    localparam int ZONE_ANY       = 3;

    three_key_debouncer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .joystick_level (joystick_level),
        .dec_pin_level  (dec_pin_level),
        .inc_pin_level  (inc_pin_level),
        .set_pin_level  (set_pin_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sampled        (sampled),
        .press_events   (press_events),
        .release_events (release_events),
        .held_keys      (held_keys)
    );

    three_key_debouncer_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .joystick_level (joystick_level),
        .dec_pin_level  (dec_pin_level),
        .inc_pin_level  (inc_pin_level),
        .set_pin_level  (set_pin_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sampled        (sampled),
        .press_events   (press_events),
        .release_events (release_events),
        .held_keys      (held_keys),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("three_key_debouncer test failed");
        $finish;
    end

    // receiver: periodically picks a new random stall style
    initial
    begin : receiver
        int rx_style;
        int rx_cycle;
        int stall_left;
        rx_style   = 0;
        rx_cycle   = 0;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 150 == 0)
                rx_style = $urandom_range(0, 3);
            if (full_speed)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                case (rx_style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= (rx_cycle % 4 == 0);
                    default:
                    begin
                        // long stalls now and then
                        if (stall_left > 0)
                        begin
                            out_ready <= 1'b0;
                            stall_left--;
                        end
                        else
                        begin
                            out_ready <= 1'b1;
                            if ($urandom_range(0, 9) == 0)
                                stall_left = $urandom_range(1, 12);
                        end
                    end
                endcase
            end
        end
    end

    // one tick item; valid stays up across back-to-back items
    task automatic send_tick(input logic [9:0] joy, input logic dec_l, input logic inc_l,
                             input logic set_l);
        @(negedge clk);
        in_valid       <= 1'b1;
        joystick_level <= joy;
        dec_pin_level  <= dec_l;
        inc_pin_level  <= inc_l;
        set_pin_level  <= set_l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // item taken at this edge; maybe close the burst with a gap
        if (!full_speed)
        begin
            if (burst_left == 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(0, 6))
                    @(negedge clk);
                burst_left = $urandom_range(0, 24);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // stop sending and wait until every expected result item has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // all three registers, unused upper data bits filled with noise
    task automatic set_config(input logic mode, input logic [3:0] count,
                              input logic [15:0] period);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(CFG_INPUT_MODE, {junk[15:1], mode});
        junk = 16'($urandom);
        write_reg(CFG_DEBOUNCE_COUNT, {junk[15:4], count});
        write_reg(CFG_SAMPLE_PERIOD, period);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [9:0] joy_in_zone(input int zone);
        case (zone)
            ZONE_DEC_PRESS: return 10'($urandom_range(0, 60));
            // inside both release windows
            ZONE_RELEASE:   return 10'($urandom_range(400, 599));
            ZONE_INC_PRESS: return 10'($urandom_range(800, 1023));
            default:        return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // one random phase: mostly steady key patterns long enough to flip keys,
    // with bounces, plus short stretches of pure noise
    task automatic run_phase(input logic mode, input logic [3:0] count,
                             input logic [15:0] period, input int n_items);
        int          sent;
        int          seg_len;
        int          eff_count;
        int          zone;
        logic [2:0]  target;
        logic [2:0]  pins;
        logic [9:0]  joy;
        sent = 0;
        eff_count = (count == 0) ? 1 : count;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 39) == 0)
                drain();
            if ($urandom_range(0, 3) != 0)
            begin
                target = 3'($urandom);
                zone = (mode == MODE_JOYSTICK) ? $urandom_range(0, 2) : ZONE_ANY;
                seg_len = eff_count * (period + 1) + $urandom_range(0, period + 1);
                // keep the phase near its item budget
                if (seg_len > n_items - sent)
                    seg_len = n_items - sent;
                repeat (seg_len)
                begin
                    pins = ~target;
                    joy  = joy_in_zone(zone);
                    // a bounce breaks the run of agreeing samples
                    if ($urandom_range(0, 11) == 0)
                    begin
                        pins[2'($urandom_range(0, 2))] ^= 1'b1;
                        joy = joy_in_zone(ZONE_ANY);
                    end
                    // pins unused in joystick mode still toggle
                    if (mode == MODE_JOYSTICK)
                        pins[1:0] = 2'($urandom);
                    send_tick(joy, pins[0], pins[1], pins[2]);
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    pins = 3'($urandom);
                    send_tick(joy_in_zone(ZONE_ANY), pins[0], pins[1], pins[2]);
                    sent++;
                end
            end
        end
    endtask

    // main stimulus
    initial
    begin : stimulus
        logic        mode;
        logic [3:0]  count;
        logic [15:0] period;
        logic [2:0]  pins;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        joystick_level = '0;
        dec_pin_level  = 1'b1;
        inc_pin_level  = 1'b1;
        set_pin_level  = 1'b1;
        full_speed     = 1'b0;
        burst_left     = 0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: these first ticks take no sample
        send_tick(10'd0, 1'b0, 1'b0, 1'b0);
        send_tick(10'h3FF, 1'b1, 1'b1, 1'b1);
        send_tick(10'd512, 1'b0, 1'b1, 1'b0);

        // zero debounce count acts like one; period 0 samples every tick
        drain();
        set_config(MODE_BUTTON, 4'd0, 16'd0);
        send_tick(10'h2AA, 1'b0, 1'b0, 1'b0);
        send_tick(10'h155, 1'b1, 1'b1, 1'b1);
        send_tick(10'd7, 1'b0, 1'b1, 1'b0);

        // count up under the largest count, then lower it mid-count
        drain();
        set_config(MODE_BUTTON, 4'd15, 16'd0);
        repeat (4)
            send_tick(10'd100, 1'b1, 1'b0, 1'b1);
        drain();
        set_config(MODE_BUTTON, 4'd2, 16'd0);
        send_tick(10'd100, 1'b1, 1'b0, 1'b1);

        // joystick window edges, one sample per tick
        drain();
        set_config(MODE_JOYSTICK, 4'd1, 16'd0);
        send_tick(10'd60, 1'b1, 1'b0, 1'b0);
        send_tick(10'd61, 1'b0, 1'b1, 1'b1);
        send_tick(10'd0, 1'b1, 1'b1, 1'b0);
        send_tick(10'd1023, 1'b0, 1'b0, 1'b1);
        send_tick(10'd800, 1'b1, 1'b0, 1'b0);
        send_tick(10'd799, 1'b0, 1'b1, 1'b1);
        send_tick(10'd400, 1'b1, 1'b1, 1'b0);
        send_tick(10'd399, 1'b0, 1'b0, 1'b1);
        send_tick(10'd599, 1'b1, 1'b0, 1'b0);
        send_tick(10'd600, 1'b0, 1'b1, 1'b1);
        send_tick(10'd300, 1'b1, 1'b1, 1'b0);
        send_tick(10'd301, 1'b0, 1'b0, 1'b1);
        send_tick(10'd700, 1'b1, 1'b0, 1'b0);
        send_tick(10'd701, 1'b0, 1'b1, 1'b1);

        // largest period: a short flat-out run that takes no sample
        drain();
        set_config(MODE_BUTTON, 4'd1, 16'hFFFF);
        full_speed = 1'b1;
        for (int n = 0; n < 16; n++)
        begin
            pins = 3'($urandom);
            send_tick(joy_in_zone(ZONE_ANY), pins[0], pins[1], pins[2]);
        end
        drain();
        full_speed = 1'b0;

        // random phases, each with its own settings
        for (int phase = 0; phase < 12; phase++)
        begin
            mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       count = 4'd1;
                1:       count = 4'd15;
                default: count = 4'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 5))
                0:       period = 16'd0;
                1:       period = 16'd1;
                2:       period = (phase % 4 == 0) ? 16'($urandom_range(9, 30)) : 16'd3;
                default: period = 16'($urandom_range(2, 8));
            endcase
            drain();
            set_config(mode, count, period);
            run_phase(mode, count, period, 104);
        end

        // all sent: wait for the tail, then report the verdict
        drain();
        repeat (8)
            @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("three_key_debouncer test passed");
        else
            $display("three_key_debouncer test failed");
        $finish;
    end

endmodule
